// ----- hw/rtl/base64_codec_assert.svh -----
// Assertion macros for the base64 codec
`ifndef BASE64_CODEC_ASSERT_SVH
`define BASE64_CODEC_ASSERT_SVH

// property holds on every clock edge outside reset
`define B64_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the same cycle
`define B64_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent in one cycle implies consequent in the next cycle
`define B64_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/b64_pkg.sv -----
// Shared types, constants and alphabet functions for the base64 codec
package b64_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned MAX_RES     = 4;
	localparam int unsigned CNT_W       = $clog2(MAX_RES + 1);
	localparam int unsigned IDX_W       = $clog2(MAX_RES);
	localparam int unsigned PEND_W      = 3;
	localparam int unsigned ACC_W       = 8;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	typedef struct packed {
		logic [CNT_W-1:0]            cnt;
		logic [MAX_RES-1:0][7:0]     data;
		logic                        mark;
		logic                        last;
		logic                        halted;
	} entry_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] val;
	} dec_t;

	function automatic logic [7:0] enc_char(input logic [5:0] six);
		logic [7:0] c;
		c = 8'h2F;
		if (six < 6'd26) begin
			c = 8'h41 + {2'b00, six};
		end else if (six < 6'd52) begin
			c = 8'h61 + {2'b00, six - 6'd26};
		end else if (six < 6'd62) begin
			c = 8'h30 + {2'b00, six - 6'd52};
		end else if (six == 6'd62) begin
			c = 8'h2B;
		end
		return c;
	endfunction

	function automatic dec_t dec_char(input logic [7:0] c);
		dec_t r;
		r.ok  = 1'b1;
		r.val = 6'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r.val = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r.val = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r.val = 6'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			r.val = 6'd62;
		end else if (c == 8'h2F) begin
			r.val = 6'd63;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/b64_front.sv -----
// Front end: accepts items, keeps message state and builds result groups
module b64_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic            cfg_mode,
	input  logic            in_accept,
	input  logic [7:0]      in_byte,
	input  logic            in_last,
	output logic            push,
	output b64_pkg::entry_t entry
);
	import b64_pkg::*;

	logic              mode_q;
	logic [ACC_W-1:0]  acc_q;
	logic [PEND_W-1:0] pend_q;
	logic              stop_q;

	logic [ACC_W-1:0]  acc_d;
	logic [PEND_W-1:0] pend_d;
	logic              stop_d;
	logic [13:0]       enc_acc;
	logic [13:0]       dec_acc;
	dec_t              look;
	entry_t            e;

	always_comb begin
		enc_acc = {acc_q[5:0], in_byte};
		look    = dec_char(in_byte);
		dec_acc = {acc_q, look.val};
		e       = '0;
		acc_d   = acc_q;
		pend_d  = pend_q;
		stop_d  = stop_q;
		if (!mode_q) begin
			acc_d = enc_acc[ACC_W-1:0];
			unique case (pend_q)
				3'd0: begin
					e.data[0] = enc_char(enc_acc[7:2]);
					pend_d    = 3'd2;
					if (in_last) begin
						e.data[1] = enc_char({enc_acc[1:0], 4'b0000});
						e.data[2] = PAD_CHAR;
						e.data[3] = PAD_CHAR;
						e.cnt     = CNT_W'(4);
					end else begin
						e.cnt = CNT_W'(1);
					end
				end
				3'd2: begin
					e.data[0] = enc_char(enc_acc[9:4]);
					pend_d    = 3'd4;
					if (in_last) begin
						e.data[1] = enc_char({enc_acc[3:0], 2'b00});
						e.data[2] = PAD_CHAR;
						e.cnt     = CNT_W'(3);
					end else begin
						e.cnt = CNT_W'(1);
					end
				end
				default: begin
					e.data[0] = enc_char(enc_acc[11:6]);
					e.data[1] = enc_char(enc_acc[5:0]);
					e.cnt     = CNT_W'(2);
					pend_d    = 3'd0;
				end
			endcase
		end else if (!stop_q) begin
			if (!look.ok) begin
				stop_d = 1'b1;
			end else begin
				acc_d = dec_acc[ACC_W-1:0];
				unique case (pend_q)
					3'd0: begin
						pend_d = 3'd6;
					end
					3'd2: begin
						e.data[0] = dec_acc[7:0];
						e.cnt     = CNT_W'(1);
						pend_d    = 3'd0;
					end
					3'd4: begin
						e.data[0] = dec_acc[9:2];
						e.cnt     = CNT_W'(1);
						pend_d    = 3'd2;
					end
					default: begin
						e.data[0] = dec_acc[11:4];
						e.cnt     = CNT_W'(1);
						pend_d    = 3'd4;
					end
				endcase
			end
		end
		if (in_last) begin
			e.last = 1'b1;
			if (e.cnt == '0) begin
				e.cnt    = CNT_W'(1);
				e.mark   = 1'b1;
				e.halted = stop_d;
			end
		end
	end

	assign entry = e;
	assign push  = in_accept && (e.cnt != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			acc_q  <= '0;
			pend_q <= '0;
			stop_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_mode;
			acc_q  <= '0;
			pend_q <= '0;
			stop_q <= 1'b0;
		end else if (in_accept) begin
			if (in_last) begin
				acc_q  <= '0;
				pend_q <= '0;
				stop_q <= 1'b0;
			end else begin
				acc_q  <= acc_d;
				pend_q <= pend_d;
				stop_q <= stop_d;
			end
		end
	end

endmodule

// ----- hw/rtl/b64_queue.sv -----
// Short queue of result groups between front and back end
module b64_queue #(
	parameter int unsigned DEPTH = b64_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  b64_pkg::entry_t wdata,
	input  logic            pop,
	output b64_pkg::entry_t rdata,
	output logic            empty,
	output logic            full
);
	import b64_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_Q = $clog2(DEPTH + 1);

	entry_t           slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_Q-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_Q'(DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/b64_back.sv -----
// Back end: walks each result group and drives the output register
module b64_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  b64_pkg::entry_t head,
	output logic            pop,
	input  logic            res_stall,
	output logic            res_valid,
	output logic [7:0]      out_byte,
	output logic            out_valid,
	output logic            out_last,
	output logic            halted
);
	import b64_pkg::*;

	logic [IDX_W-1:0] idx_q;
	logic             res_valid_q;
	logic [7:0]       byte_q;
	logic             dvalid_q;
	logic             last_q;
	logic             halted_q;
	logic             adv;
	logic             final_item;

	assign adv        = head_valid && (!res_valid_q || !res_stall);
	assign final_item = (CNT_W'(idx_q) == head.cnt - CNT_W'(1));
	assign pop        = adv && final_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				res_valid_q <= 1'b1;
				idx_q       <= final_item ? '0 : idx_q + 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_q   <= head.data[idx_q];
			dvalid_q <= !head.mark;
			last_q   <= head.last && final_item;
			halted_q <= head.halted;
		end
	end

	assign res_valid = res_valid_q;
	assign out_byte  = byte_q;
	assign out_valid = dvalid_q;
	assign out_last  = last_q;
	assign halted    = halted_q;

endmodule

// ----- hw/rtl/base64_codec.sv -----
// Top level of the streaming base64 encoder and decoder
// A first result passes a queue slot, then the output register; results follow one per cycle
// while res_stall is low. Items are taken every cycle while the queue has room; results per
// item set the rate at the single output port: decode 0-1, encode 1-2, last up to 4.
// Reset selects encode, clears message state and empties the queue and output register.
`include "base64_codec_assert.svh"

module base64_codec #(
	parameter int unsigned QUEUE_DEPTH = b64_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       decode_mode,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] out_byte,
	output logic       out_valid,
	output logic       out_last,
	output logic       halted
);
	import b64_pkg::*;

	entry_t push_entry;
	entry_t head;
	logic   push;
	logic   pop;
	logic   q_empty;
	logic   q_full;
	logic   in_accept;
	logic   cfg_we;

	assign in_stall  = q_full;
	assign in_accept = in_valid && !q_full;
	assign cfg_ready = q_empty && !res_valid;
	assign cfg_we    = cfg_valid && cfg_ready;

	b64_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_mode  (decode_mode),
		.in_accept (in_accept),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.push      (push),
		.entry     (push_entry)
	);

	b64_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_entry),
		.pop    (pop),
		.rdata  (head),
		.empty  (q_empty),
		.full   (q_full)
	);

	b64_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!q_empty),
		.head       (head),
		.pop        (pop),
		.res_stall  (res_stall),
		.res_valid  (res_valid),
		.out_byte   (out_byte),
		.out_valid  (out_valid),
		.out_last   (out_last),
		.halted     (halted)
	);

	`B64_ASSERT_NOW(a_marker_is_last, res_valid && !out_valid, out_last, "end marker without last")
	`B64_ASSERT_NOW(a_halt_on_marker, res_valid && halted, !out_valid, "halted on a data result")
	`B64_ASSERT(a_full_has_output, !in_stall || res_valid, "queue full with empty output")
	`B64_ASSERT_NEXT(a_cfg_idle, cfg_valid && cfg_ready, !res_valid, "result after mode write")

endmodule
